/* design/est_pkg.sv */
// ----------------------------------------------------------------------------
// est_pkg: shared types and constants for the encoder scan tracker
// Opcodes, register indexes, field widths and the request and result structs.
// ----------------------------------------------------------------------------
package est_pkg;

  // field widths
  localparam int POS_W     = 32;
  localparam int STILL_W   = 16;
  localparam int WDT_W     = 16;
  localparam int RELOAD_W  = 15;
  localparam int DIST_W    = 20;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;
  localparam int EXT_W     = POS_W + 2;

  // capture store layout
  localparam int NSLOT  = 3;
  localparam int NCAP   = 2 * NSLOT;
  localparam int BEAT_W = 3;
  localparam int CNT_W  = 2;

  // stream widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 128;

  // fixed values
  localparam logic [WDT_W-1:0]    WDT_IDLE          = 16'hFFFF;
  localparam logic [STILL_W-1:0]  STILL_MAX         = 16'hFFFF;
  localparam logic [RELOAD_W-1:0] RST_WDT_RELOAD    = 15'd500;
  localparam logic [DIST_W-1:0]   RST_POLE_SPACING  = 20'd2000;
  localparam logic [DIST_W-1:0]   RST_FIRST_GAP     = 20'd1800;
  localparam logic [BEAT_W-1:0]   BEAT_LAST         = 3'(NCAP - 1);
  localparam logic [BEAT_W-1:0]   BEAT_DIR1         = 3'(NSLOT);

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_INDEX     = 3'd1,
    OP_READ      = 3'd2,
    OP_WDT_START = 3'd3,
    OP_WDT_STOP  = 3'd4,
    OP_WDT_KICK  = 3'd5,
    OP_WDT_CHECK = 3'd6
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WDT_RELOAD   = 2'd0,
    CFG_POLE_SPACING = 2'd1,
    CFG_FIRST_GAP    = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SCAN_WAIT = 2'd0,
    SCAN_NONE = 2'd1,
    SCAN_NEW  = 2'd2
  } scan_t;

  // decoded request, one strobe per action
  typedef struct packed {
    logic tick_move;
    logic tick_wdt;
    logic index;
    logic read_ok;
    logic wdt_start;
    logic wdt_stop;
    logic wdt_kick;
    logic wdt_check;
  } cmd_t;

  // tracker status after the update
  typedef struct packed {
    logic                    going_down;
    logic signed [POS_W-1:0] low_turn;
    logic signed [POS_W-1:0] high_turn;
    logic [STILL_W-1:0]      still;
    scan_t                   scan;
    logic                    armed;
  } status_t;

  // one result beat, last field in the lowest bits
  typedef struct packed {
    logic signed [POS_W-1:0] pole_position;
    logic [CNT_W-1:0]        pole_count;
    logic [1:0]              pole_slot;
    logic                    pole_dir;
    logic                    capture_armed;
    logic [1:0]              scan_state;
    logic [STILL_W-1:0]      still_count;
    logic signed [POS_W-1:0] max_position;
    logic signed [POS_W-1:0] min_position;
    logic                    moving_down;
    logic                    flag;
  } result_t;

  localparam int PAD_W = OUT_TDATA_W - $bits(result_t);

endpackage

/* design/est_tracker.sv */
// ----------------------------------------------------------------------------
// est_tracker: direction, turning points, scan state and capture arming
// Follows the encoder position on collecting ticks and counts still samples.
// ----------------------------------------------------------------------------
module est_tracker import est_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  input  logic signed [POS_W-1:0] pos,
  output status_t                 status_nxt,
  output logic                    going_down,
  output logic                    armed,
  output logic                    clear_req
);

  logic                    going_down_r, going_down_nxt;
  logic signed [POS_W-1:0] prev_r, prev_nxt;
  logic signed [POS_W-1:0] low_r, low_nxt;
  logic signed [POS_W-1:0] high_r, high_nxt;
  logic [STILL_W-1:0]      still_r, still_nxt;
  scan_t                   scan_r, scan_nxt;
  logic                    armed_r, armed_nxt;

  // tick update
  always_comb begin
    going_down_nxt = going_down_r;
    prev_nxt       = prev_r;
    low_nxt        = low_r;
    high_nxt       = high_r;
    still_nxt      = still_r;
    scan_nxt       = scan_r;
    armed_nxt      = armed_r;
    clear_req      = 1'b0;
    if (cmd.tick_move) begin
      if (going_down_r) begin
        if (pos > prev_r) begin
          low_nxt        = prev_r;
          going_down_nxt = 1'b0;
        end
      end else if (pos < prev_r) begin
        high_nxt       = prev_r;
        going_down_nxt = 1'b1;
        if (scan_r == SCAN_WAIT) begin
          clear_req = 1'b1;
          armed_nxt = 1'b1;
          scan_nxt  = SCAN_NONE;
        end else begin
          if (armed_r) begin
            armed_nxt = 1'b0;
          end else begin
            clear_req = 1'b1;
            armed_nxt = 1'b1;
          end
          scan_nxt = SCAN_NEW;
        end
      end
      // still counter, saturating
      if (pos == prev_r) begin
        if (still_r != STILL_MAX) begin
          still_nxt = still_r + 1'b1;
        end
      end else begin
        still_nxt = '0;
      end
      prev_nxt = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      going_down_r <= 1'b0;
      prev_r       <= '0;
      low_r        <= '0;
      high_r       <= '0;
      still_r      <= '0;
      scan_r       <= SCAN_WAIT;
      armed_r      <= 1'b0;
    end else begin
      going_down_r <= going_down_nxt;
      prev_r       <= prev_nxt;
      low_r        <= low_nxt;
      high_r       <= high_nxt;
      still_r      <= still_nxt;
      scan_r       <= scan_nxt;
      armed_r      <= armed_nxt;
    end
  end

  assign status_nxt.going_down = going_down_nxt;
  assign status_nxt.low_turn   = low_nxt;
  assign status_nxt.high_turn  = high_nxt;
  assign status_nxt.still      = still_nxt;
  assign status_nxt.scan       = scan_nxt;
  assign status_nxt.armed      = armed_nxt;
  assign going_down            = going_down_r;
  assign armed                 = armed_r;

endmodule

/* design/est_poles.sv */
// ----------------------------------------------------------------------------
// est_poles: pole capture store
// Records index pulse positions per direction with spacing checks.
// ----------------------------------------------------------------------------
module est_poles import est_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  input  logic signed [POS_W-1:0] pos,
  input  logic                    going_down,
  input  logic                    armed,
  input  logic                    clear_req,
  input  logic [DIST_W-1:0]       pole_spacing,
  input  logic [DIST_W-1:0]       first_pole_gap,
  output logic [CNT_W-1:0]        cnt [2],
  output logic signed [POS_W-1:0] store [NCAP]
);

  logic [CNT_W-1:0]        cnt_r [2];
  logic signed [POS_W-1:0] store_r [NCAP];
  logic signed [POS_W-1:0] last_cap_r;

  logic                    dir;
  logic [CNT_W-1:0]        cur_cnt;
  logic signed [EXT_W-1:0] p_ext, pr_ext, sp_ext, gap_ext;
  logic                    spacing_ok, gap_fail;
  logic                    store_en;
  logic [1:0]              slot;
  logic [BEAT_W-1:0]       wr_idx;

  // distance checks at widened precision
  assign dir     = going_down;
  assign cur_cnt = cnt_r[dir];
  assign p_ext   = EXT_W'(pos);
  assign pr_ext  = EXT_W'(last_cap_r);
  assign sp_ext  = EXT_W'({1'b0, pole_spacing});
  assign gap_ext = EXT_W'({1'b0, first_pole_gap});

  assign spacing_ok = dir ? (pr_ext >= p_ext + sp_ext) : (pr_ext + sp_ext <= p_ext);
  assign gap_fail   = dir ? (pr_ext < p_ext + gap_ext) : (pr_ext + gap_ext > p_ext);

  // slot selection for an index pulse
  always_comb begin
    store_en = 1'b0;
    slot     = 2'd0;
    case (cur_cnt)
      2'd0: begin
        store_en = 1'b1;
        slot     = 2'd0;
      end
      2'd1: begin
        store_en = 1'b1;
        slot     = gap_fail ? 2'd0 : 2'd1;
      end
      2'd2: begin
        store_en = spacing_ok;
        slot     = 2'd2;
      end
      default: begin
        store_en = 1'b0;
        slot     = 2'd0;
      end
    endcase
    store_en = store_en & cmd.index & armed;
  end

  assign wr_idx = dir ? (BEAT_DIR1 + {1'b0, slot}) : {1'b0, slot};

  // store update, cleared on rearm or after a read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r[0]   <= '0;
      cnt_r[1]   <= '0;
      last_cap_r <= '0;
      for (int i = 0; i < NCAP; i++) begin
        store_r[i] <= '0;
      end
    end else if (clear_req || cmd.read_ok) begin
      cnt_r[0] <= '0;
      cnt_r[1] <= '0;
      for (int i = 0; i < NCAP; i++) begin
        store_r[i] <= '0;
      end
    end else if (store_en) begin
      cnt_r[dir]      <= slot + 2'd1;
      store_r[wr_idx] <= pos;
      last_cap_r      <= pos;
    end
  end

  assign cnt   = cnt_r;
  assign store = store_r;

endmodule

/* design/est_wdt.sv */
// ----------------------------------------------------------------------------
// est_wdt: move watchdog
// Counts down on idle ticks, fires at zero, and is started, stopped, kicked.
// ----------------------------------------------------------------------------
module est_wdt import est_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  input  logic [RELOAD_W-1:0] reload,
  output logic                fired
);

  logic [WDT_W-1:0] left_r, left_nxt;
  logic             fired_r, fired_nxt;

  // countdown and control
  always_comb begin
    left_nxt  = left_r;
    fired_nxt = fired_r;
    if (cmd.tick_wdt && !left_r[WDT_W-1]) begin
      if (left_r != '0) begin
        left_nxt = left_r - 1'b1;
      end else begin
        fired_nxt = 1'b1;
        left_nxt  = WDT_IDLE;
      end
    end
    if (cmd.wdt_start) begin
      left_nxt  = {1'b0, reload};
      fired_nxt = 1'b0;
    end
    if (cmd.wdt_stop) begin
      left_nxt = WDT_IDLE;
    end
    if (cmd.wdt_kick) begin
      left_nxt = {1'b0, reload};
    end
    if (cmd.wdt_check) begin
      fired_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= WDT_IDLE;
      fired_r <= 1'b0;
    end else begin
      left_r  <= left_nxt;
      fired_r <= fired_nxt;
    end
  end

  assign fired = fired_r;

endmodule

/* design/est_out.sv */
// ----------------------------------------------------------------------------
// est_out: result register and read sequencer
// Holds one status result, or a snapshot of the six captures sent as six beats.
// ----------------------------------------------------------------------------
module est_out import est_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  logic                    flag,
  input  logic                    multi,
  input  status_t                 status,
  input  logic [CNT_W-1:0]        cnt [2],
  input  logic signed [POS_W-1:0] store [NCAP],
  output logic                    ready,
  input  logic                    out_tready,
  output logic                    out_tvalid,
  output logic                    out_tlast,
  output logic [OUT_TDATA_W-1:0]  out_tdata
);

  logic                    valid_r;
  logic                    multi_r;
  logic [BEAT_W-1:0]       beat_r;
  logic                    flag_r;
  status_t                 status_r;
  logic [CNT_W-1:0]        cnt_r [2];
  logic signed [POS_W-1:0] snap_r [NCAP];

  logic                    last;
  logic                    dir;
  logic [BEAT_W-1:0]       slot_full;
  result_t                 res;

  assign last  = !multi_r || (beat_r == BEAT_LAST);
  assign ready = !valid_r || (out_tready && last);

  // control: valid and beat counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= '0;
      multi_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
      beat_r  <= '0;
      multi_r <= multi;
    end else if (valid_r && out_tready) begin
      if (last) begin
        valid_r <= 1'b0;
      end else begin
        beat_r <= beat_r + 1'b1;
      end
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (load) begin
      flag_r   <= flag;
      status_r <= status;
      cnt_r    <= cnt;
      snap_r   <= store;
    end
  end

  // beat fields
  assign dir       = (beat_r >= BEAT_DIR1);
  assign slot_full = dir ? (beat_r - BEAT_DIR1) : beat_r;

  always_comb begin
    res.flag          = flag_r;
    res.moving_down   = status_r.going_down;
    res.min_position  = status_r.low_turn;
    res.max_position  = status_r.high_turn;
    res.still_count   = status_r.still;
    res.scan_state    = status_r.scan;
    res.capture_armed = status_r.armed;
    res.pole_dir      = 1'b0;
    res.pole_slot     = '0;
    res.pole_count    = '0;
    res.pole_position = '0;
    if (multi_r) begin
      res.pole_dir      = dir;
      res.pole_slot     = slot_full[1:0];
      res.pole_count    = cnt_r[dir];
      res.pole_position = snap_r[beat_r];
    end
  end

  assign out_tvalid = valid_r;
  assign out_tlast  = last;
  assign out_tdata  = {{PAD_W{1'b0}}, res};

endmodule

/* design/encoder_scan_tracker_core.sv */
// ----------------------------------------------------------------------------
// encoder_scan_tracker_core: encoder scan tracker top level
// The first result beat of an accepted request is registered for the next cycle.
// Throughput: one request per cycle unless out_tready or a read in progress
// holds it off; a successful read gives six beats, the next request being taken
// with the sixth beat. The result register and its sequencer set the read rate.
// Reset: synchronous, active low; clears control state, config registers to defaults.
// ----------------------------------------------------------------------------
module encoder_scan_tracker_core import est_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata,
  // request stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // opcode[2:0], position[34:3], collecting[35], zero fill above
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic                   out_tlast,
  // flag[0], moving_down[1], min_position[33:2], max_position[65:34],
  // still_count[81:66], scan_state[83:82], capture_armed[84], pole_dir[85],
  // pole_slot[87:86], pole_count[89:88], pole_position[121:90], zero fill above
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [RELOAD_W-1:0]     wdt_reload_r;
  logic [DIST_W-1:0]       pole_spacing_r;
  logic [DIST_W-1:0]       first_gap_r;

  logic                    accept;
  op_t                     op;
  logic signed [POS_W-1:0] pos;
  logic                    collecting;
  cmd_t                    cmd;

  status_t                 status_nxt;
  logic                    going_down, armed, clear_req;
  logic                    wdt_fired;
  logic [CNT_W-1:0]        cnt [2];
  logic signed [POS_W-1:0] store [NCAP];
  logic                    flag;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wdt_reload_r   <= RST_WDT_RELOAD;
      pole_spacing_r <= RST_POLE_SPACING;
      first_gap_r    <= RST_FIRST_GAP;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_WDT_RELOAD:   wdt_reload_r   <= cfg_wdata[RELOAD_W-1:0];
        CFG_POLE_SPACING: pole_spacing_r <= cfg_wdata;
        CFG_FIRST_GAP:    first_gap_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // request unpack
  assign accept     = in_tvalid && in_tready;
  assign op         = op_t'(in_tdata[2:0]);
  assign pos        = in_tdata[34:3];
  assign collecting = in_tdata[35];

  // opcode decode
  always_comb begin
    cmd = '0;
    if (accept) begin
      case (op)
        OP_TICK: begin
          cmd.tick_move = collecting;
          cmd.tick_wdt  = !collecting;
        end
        OP_INDEX:     cmd.index     = 1'b1;
        OP_READ:      cmd.read_ok   = !armed;
        OP_WDT_START: cmd.wdt_start = 1'b1;
        OP_WDT_STOP:  cmd.wdt_stop  = 1'b1;
        OP_WDT_KICK:  cmd.wdt_kick  = 1'b1;
        OP_WDT_CHECK: cmd.wdt_check = 1'b1;
        default: ;
      endcase
    end
  end

  assign flag = cmd.read_ok || (cmd.wdt_check && wdt_fired);

  est_tracker u_tracker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .pos        (pos),
    .status_nxt (status_nxt),
    .going_down (going_down),
    .armed      (armed),
    .clear_req  (clear_req)
  );

  est_poles u_poles (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .pos            (pos),
    .going_down     (going_down),
    .armed          (armed),
    .clear_req      (clear_req),
    .pole_spacing   (pole_spacing_r),
    .first_pole_gap (first_gap_r),
    .cnt            (cnt),
    .store          (store)
  );

  est_wdt u_wdt (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .reload (wdt_reload_r),
    .fired  (wdt_fired)
  );

  est_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .flag       (flag),
    .multi      (cmd.read_ok),
    .status     (status_nxt),
    .cnt        (cnt),
    .store      (store),
    .ready      (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tlast  (out_tlast),
    .out_tdata  (out_tdata)
  );

endmodule
